[sv/rlp_pkg.sv]
`default_nettype none
package rlp_pkg;

   // divider geometry: dividend, divisor and quotient widths
   localparam int DIVN_W = 62;
   localparam int DIVD_W = 38;

   // in-field value widths (all values are bounded once the field check passes)
   localparam int XP_W  = 26;
   localparam int RS_W  = 26;
   localparam int RSS_W = 28;
   localparam int RSC_W = 29;
   localparam int T2_W  = 28;
   localparam int XY_W  = 27;

   localparam int Q24_SH    = 24;
   localparam int CSR_IDX_W = 3;

   localparam logic signed [63:0] ONE_Q48      = 64'sd1 <<< 48;
   localparam logic [DIVD_W-1:0]  ONE_Q24_DEN  = DIVD_W'(1) << Q24_SH;
   localparam logic [63:0]        FIELD_LIM_SQ = 64'd28521267 * 64'd28521267;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_DEPTH  = 2'd1,
      ST_FIELD  = 2'd2,
      ST_CONFIG = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FOCAL     = 3'd0,
      REG_PRINCIPAL = 3'd1,
      REG_RAD_NUM   = 3'd2,
      REG_RAD_MIXED = 3'd3,
      REG_RAD_DEN   = 3'd4,
      REG_TANGENT   = 3'd5,
      REG_CENTRE    = 3'd6
   } reg_index_type;

   // sideband that rides along with a division
   typedef struct packed {
      status_type              status;
      logic                    sign_a;
      logic                    sign_b;
      logic signed [XP_W-1:0]  xp;
      logic signed [XP_W-1:0]  yp;
      logic [T2_W-1:0]         tx2;
      logic [T2_W-1:0]         ty2;
      logic signed [XY_W-1:0]  xy24;
   } div_side_type;

   function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // divide by 2^24 with truncation toward zero
   function automatic logic signed [63:0] trunc_q24(input logic signed [63:0] v);
      if (v[63]) return -((-v) >>> Q24_SH);
      return v >>> Q24_SH;
   endfunction

endpackage
`default_nettype wire

[sv/rlp_ifs.sv]
`default_nettype none
interface rlp_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;
   logic signed [31:0] point_z;
   modport source (output valid, point_x, point_y, point_z, input ready);
   modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface rlp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pixel_u;
   logic signed [31:0] pixel_v;
   logic [1:0]         status;
   modport source (output valid, pixel_u, pixel_v, status, input ready);
   modport sink   (input valid, pixel_u, pixel_v, status, output ready);
endinterface
`default_nettype wire

[sv/rlp_divider.sv]
`default_nettype none
module rlp_divider import rlp_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               ce,
   input  wire logic               in_valid,
   input  wire logic [DIVN_W-1:0]  in_num,
   input  wire logic [DIVD_W-1:0]  in_den,
   input  wire div_side_type       in_side,
   output logic                    out_valid,
   output logic [DIVN_W-1:0]       out_quo,
   output div_side_type            out_side
);

   // restoring division, one quotient bit per stage
   logic [DIVN_W-1:0] vld_ff;
   logic [DIVD_W-1:0] rem_ff [DIVN_W];
   logic [DIVD_W-1:0] rem_in [DIVN_W];
   logic [DIVN_W-1:0] num_ff [DIVN_W];
   logic [DIVN_W-1:0] num_in [DIVN_W];
   logic [DIVN_W-1:0] quo_ff [DIVN_W];
   logic [DIVN_W-1:0] quo_in [DIVN_W];
   logic [DIVD_W-1:0] den_ff [DIVN_W];
   div_side_type      side_ff [DIVN_W];

   always_comb begin
      logic [DIVD_W:0]   trial;
      logic [DIVD_W-1:0] rem_p;
      logic [DIVD_W-1:0] den_p;
      logic [DIVN_W-1:0] num_p;
      logic [DIVN_W-1:0] quo_p;
      for (int s = 0; s < DIVN_W; s++) begin
         if (s == 0) begin
            rem_p = '0;
            den_p = in_den;
            num_p = in_num;
            quo_p = '0;
         end else begin
            rem_p = rem_ff[s-1];
            den_p = den_ff[s-1];
            num_p = num_ff[s-1];
            quo_p = quo_ff[s-1];
         end
         trial     = {rem_p, num_p[DIVN_W-1]};
         num_in[s] = {num_p[DIVN_W-2:0], 1'b0};
         if (trial >= {1'b0, den_p}) begin
            rem_in[s] = DIVD_W'(trial - {1'b0, den_p});
            quo_in[s] = {quo_p[DIVN_W-2:0], 1'b1};
         end else begin
            rem_in[s] = trial[DIVD_W-1:0];
            quo_in[s] = {quo_p[DIVN_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ce) begin
         vld_ff <= {vld_ff[DIVN_W-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         for (int s = 0; s < DIVN_W; s++) begin
            rem_ff[s] <= rem_in[s];
            num_ff[s] <= num_in[s];
            quo_ff[s] <= quo_in[s];
         end
         den_ff[0]  <= in_den;
         side_ff[0] <= in_side;
         for (int s = 1; s < DIVN_W; s++) begin
            den_ff[s]  <= den_ff[s-1];
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   assign out_valid = vld_ff[DIVN_W-1];
   assign out_quo   = quo_ff[DIVN_W-1];
   assign out_side  = side_ff[DIVN_W-1];

endmodule
`default_nettype wire

[sv/rational_lens_projection_core.sv]
`default_nettype none
// Rational-lens projection core. Takes one camera-space point (Q16.16) per
// transaction and returns one pixel (Q20.12) with a status code: ok, depth not
// positive, out of field, or bad focal length; pixels are zero unless ok. The
// core accepts one point every cycle while the output queue is not full. A
// point's result passes two 62-step restoring divisions (depth normalization
// in a pair of dividers for x and y, then the rational radial ratio) and 17
// arithmetic stages. A two-entry output queue takes up to two results while
// the sink stalls; the whole pipeline holds only when that queue is full.
// Configuration registers must be written only while no point is in flight.
module rational_lens_projection_core import rlp_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   rlp_req_if.sink                   req_chan,
   rlp_rsp_if.source                 rsp_chan,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [63:0]          csr_wdata
);

   typedef struct packed {
      logic signed [31:0] u;
      logic signed [31:0] v;
      status_type         status;
   } rsp_entry_type;

   // ---------------------------------------------------------------- csr
   logic [63:0] focal_ff, principal_ff, rad_num_ff, rad_mixed_ff;
   logic [63:0] rad_den_ff, tangent_ff, centre_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_ff     <= '0;
         principal_ff <= '0;
         rad_num_ff   <= '0;
         rad_mixed_ff <= '0;
         rad_den_ff   <= '0;
         tangent_ff   <= '0;
         centre_ff    <= '0;
      end else if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_FOCAL:     focal_ff     <= csr_wdata;
            REG_PRINCIPAL: principal_ff <= csr_wdata;
            REG_RAD_NUM:   rad_num_ff   <= csr_wdata;
            REG_RAD_MIXED: rad_mixed_ff <= csr_wdata;
            REG_RAD_DEN:   rad_den_ff   <= csr_wdata;
            REG_TANGENT:   tangent_ff   <= csr_wdata;
            REG_CENTRE:    centre_ff    <= csr_wdata;
            default: ;     // unknown index, write dropped
         endcase
      end
   end

   // register halves, upper half first
   logic signed [31:0] fx, fy, cx, cy, k1, k2, k3, k4, k5, k6, p1, p2, codx, cody;
   assign fx   = $signed(focal_ff[63:32]);
   assign fy   = $signed(focal_ff[31:0]);
   assign cx   = $signed(principal_ff[63:32]);
   assign cy   = $signed(principal_ff[31:0]);
   assign k1   = $signed(rad_num_ff[63:32]);
   assign k2   = $signed(rad_num_ff[31:0]);
   assign k3   = $signed(rad_mixed_ff[63:32]);
   assign k4   = $signed(rad_mixed_ff[31:0]);
   assign k5   = $signed(rad_den_ff[63:32]);
   assign k6   = $signed(rad_den_ff[31:0]);
   assign p1   = $signed(tangent_ff[63:32]);
   assign p2   = $signed(tangent_ff[31:0]);
   assign codx = $signed(centre_ff[63:32]);
   assign cody = $signed(centre_ff[31:0]);

   // ---------------------------------------------------------------- flow control
   // the pipeline advances unless the output queue is full
   rsp_entry_type q_ff [2];
   logic [1:0]    q_count_ff;
   logic          ce;
   logic          push, pop;
   rsp_entry_type push_entry;

   assign ce             = (q_count_ff != 2'd2);
   assign req_chan.ready = ce;

   // ---------------------------------------------------------------- entry
   // magnitudes go into the dividers, signs ride in the sideband
   logic [31:0]       mag_x, mag_y;
   logic [DIVD_W-1:0] den_z;
   div_side_type      side_entry;

   always_comb begin
      mag_x = req_chan.point_x[31] ? 32'(-req_chan.point_x) : req_chan.point_x;
      mag_y = req_chan.point_y[31] ? 32'(-req_chan.point_y) : req_chan.point_y;
      side_entry        = '0;
      side_entry.sign_a = req_chan.point_x[31];
      side_entry.sign_b = req_chan.point_y[31];
      if (req_chan.point_z[31] || req_chan.point_z == 32'sd0) begin
         side_entry.status = ST_DEPTH;
         den_z             = DIVD_W'(1);   // keeps the divider well defined
      end else begin
         side_entry.status = (fx <= 32'sd0 || fy <= 32'sd0) ? ST_CONFIG : ST_OK;
         den_z             = DIVD_W'(req_chan.point_z);
      end
   end

   logic              dx_valid;
   logic [DIVN_W-1:0] qx, qy;
   div_side_type      dx_side;

   rlp_divider u_div_x (
      .clock     (clock),
      .reset     (reset),
      .ce        (ce),
      .in_valid  (req_chan.valid),
      .in_num    (DIVN_W'({mag_x, 24'b0})),
      .in_den    (den_z),
      .in_side   (side_entry),
      .out_valid (dx_valid),
      .out_quo   (qx),
      .out_side  (dx_side)
   );

   rlp_divider u_div_y (
      .clock     (clock),
      .reset     (reset),
      .ce        (ce),
      .in_valid  (req_chan.valid),
      .in_num    (DIVN_W'({mag_y, 24'b0})),
      .in_den    (den_z),
      .in_side   (side_entry),
      .out_valid (),
      .out_quo   (qy),
      .out_side  ()
   );

   // ---------------------------------------------------------------- stage valids and sideband
   // stages 1..11 run from the depth division to the ratio division,
   // stages 12..17 from the ratio division to the output queue
   logic [17:1]  vld_ff;
   div_side_type side_ff [1:17];
   div_side_type side3_in, side11_in;
   logic         dr_valid;
   logic [DIVN_W-1:0] qd;
   div_side_type dr_side;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ce) begin
         vld_ff[1] <= dx_valid;
         for (int i = 2; i <= 11; i++) vld_ff[i] <= vld_ff[i-1];
         vld_ff[12] <= dr_valid;
         for (int i = 13; i <= 17; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         side_ff[1] <= dx_side;
         side_ff[2] <= side_ff[1];
         side_ff[3] <= side3_in;
         for (int i = 4; i <= 10; i++) side_ff[i] <= side_ff[i-1];
         side_ff[11] <= side11_in;
         side_ff[12] <= dr_side;
         for (int i = 13; i <= 17; i++) side_ff[i] <= side_ff[i-1];
      end
   end

   // ---------------------------------------------------------------- stage 1: signed, centred
   logic signed [31:0] xp1_ff, yp1_ff, xp1_in, yp1_in;

   always_comb begin
      logic signed [63:0] xn, yn;
      xn = $signed({2'b0, qx});
      yn = $signed({2'b0, qy});
      if (dx_side.sign_a) xn = -xn;
      if (dx_side.sign_b) yn = -yn;
      xp1_in = clamp32(xn - 64'(codx));
      yp1_in = clamp32(yn - 64'(cody));
   end

   // ---------------------------------------------------------------- stage 2: squares
   logic signed [63:0] sqx2_ff, sqy2_ff, pxy2_ff;
   logic signed [31:0] xp2_ff, yp2_ff;

   // ---------------------------------------------------------------- stage 3: radius, field check
   logic [63:0]        r2;
   logic [63:0]        tx_sum, ty_sum;
   logic signed [63:0] xy_full;
   logic [RS_W-1:0]    rs3_ff;

   always_comb begin
      r2      = $unsigned(sqx2_ff) + $unsigned(sqy2_ff);
      tx_sum  = r2 + ($unsigned(sqx2_ff) << 1);
      ty_sum  = r2 + ($unsigned(sqy2_ff) << 1);
      xy_full = trunc_q24(pxy2_ff);
      side3_in      = side_ff[2];
      side3_in.xp   = xp2_ff[XP_W-1:0];
      side3_in.yp   = yp2_ff[XP_W-1:0];
      side3_in.tx2  = tx_sum[Q24_SH +: T2_W];
      side3_in.ty2  = ty_sum[Q24_SH +: T2_W];
      side3_in.xy24 = xy_full[XY_W-1:0];
      if (side_ff[2].status == ST_OK && r2 > FIELD_LIM_SQ) side3_in.status = ST_FIELD;
   end

   // ---------------------------------------------------------------- stages 4..10: polynomials
   logic [2*RS_W-1:0]  mrss4_ff;
   logic signed [63:0] k1rs_ff [4:8];
   logic signed [63:0] k4rs_ff [4:8];
   logic [RS_W-1:0]    rs_ff   [4:5];
   logic [RSS_W-1:0]   rss5_ff;
   logic [RSS_W+RS_W-1:0] mrsc6_ff;
   logic signed [63:0] k2rss_ff [6:8];
   logic signed [63:0] k5rss_ff [6:8];
   logic [RSC_W-1:0]   rsc7_ff;
   logic signed [63:0] k3rsc8_ff, k6rsc8_ff;
   logic signed [63:0] a9_ff, b9_ff, k3rsc9_ff, k6rsc9_ff;
   logic signed [63:0] a10_ff, b10_ff;

   // ---------------------------------------------------------------- stage 11: ratio setup
   logic [DIVN_W-1:0]  amag11_ff, amag11_in;
   logic [DIVD_W-1:0]  den11_ff, den11_in;

   always_comb begin
      logic signed [63:0] aabs, babs;
      logic [DIVD_W-1:0]  bmag;
      aabs      = a10_ff[63] ? -a10_ff : a10_ff;
      babs      = b10_ff[63] ? -b10_ff : b10_ff;
      bmag      = babs[Q24_SH +: DIVD_W];
      amag11_in = aabs[DIVN_W-1:0];
      side11_in = side_ff[10];
      // zero denominator after truncation acts as one
      if (bmag == '0) begin
         den11_in         = ONE_Q24_DEN;
         side11_in.sign_a = a10_ff[63];
      end else begin
         den11_in         = bmag;
         side11_in.sign_a = a10_ff[63] ^ b10_ff[63];
      end
   end

   rlp_divider u_div_ratio (
      .clock     (clock),
      .reset     (reset),
      .ce        (ce),
      .in_valid  (vld_ff[11]),
      .in_num    (amag11_ff),
      .in_den    (den11_ff),
      .in_side   (side_ff[11]),
      .out_valid (dr_valid),
      .out_quo   (qd),
      .out_side  (dr_side)
   );

   // ---------------------------------------------------------------- stages 12..17: apply
   logic signed [31:0] d12_ff, d12_in;
   logic signed [63:0] m1x13_ff, m2x13_ff, m3x13_ff, m1y13_ff, m2y13_ff, m3y13_ff;
   logic signed [63:0] sx14_ff, sy14_ff;
   logic signed [31:0] xd15_ff, yd15_ff;
   logic signed [63:0] mu16_ff, mv16_ff;
   logic signed [31:0] u17_ff, v17_ff, u17_in, v17_in;

   always_comb begin
      logic signed [63:0] dn;
      dn = $signed({2'b0, qd});
      if (dr_side.sign_a) dn = -dn;
      d12_in = clamp32(dn);
   end

   always_comb begin
      if (side_ff[16].status == ST_OK) begin
         u17_in = clamp32(trunc_q24(mu16_ff) + 64'(cx));
         v17_in = clamp32(trunc_q24(mv16_ff) + 64'(cy));
      end else begin
         u17_in = '0;
         v17_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         // stage 1
         xp1_ff <= xp1_in;
         yp1_ff <= yp1_in;
         // stage 2
         sqx2_ff <= xp1_ff * xp1_ff;
         sqy2_ff <= yp1_ff * yp1_ff;
         pxy2_ff <= xp1_ff * yp1_ff;
         xp2_ff  <= xp1_ff;
         yp2_ff  <= yp1_ff;
         // stage 3
         rs3_ff <= r2[Q24_SH +: RS_W];
         // stage 4: r^2 terms
         mrss4_ff   <= rs3_ff * rs3_ff;
         k1rs_ff[4] <= k1 * $signed({1'b0, rs3_ff});
         k4rs_ff[4] <= k4 * $signed({1'b0, rs3_ff});
         rs_ff[4]   <= rs3_ff;
         // stage 5
         rss5_ff  <= mrss4_ff[Q24_SH +: RSS_W];
         rs_ff[5] <= rs_ff[4];
         // stage 6: r^4 terms
         mrsc6_ff    <= rss5_ff * rs_ff[5];
         k2rss_ff[6] <= k2 * $signed({1'b0, rss5_ff});
         k5rss_ff[6] <= k5 * $signed({1'b0, rss5_ff});
         // stage 7
         rsc7_ff <= mrsc6_ff[Q24_SH +: RSC_W];
         // stage 8: r^6 terms
         k3rsc8_ff <= k3 * $signed({1'b0, rsc7_ff});
         k6rsc8_ff <= k6 * $signed({1'b0, rsc7_ff});
         for (int i = 5; i <= 8; i++) begin
            k1rs_ff[i] <= k1rs_ff[i-1];
            k4rs_ff[i] <= k4rs_ff[i-1];
         end
         for (int i = 7; i <= 8; i++) begin
            k2rss_ff[i] <= k2rss_ff[i-1];
            k5rss_ff[i] <= k5rss_ff[i-1];
         end
         // stage 9, 10: numerator and denominator sums
         a9_ff     <= ONE_Q48 + k1rs_ff[8] + k2rss_ff[8];
         b9_ff     <= ONE_Q48 + k4rs_ff[8] + k5rss_ff[8];
         k3rsc9_ff <= k3rsc8_ff;
         k6rsc9_ff <= k6rsc8_ff;
         a10_ff    <= a9_ff + k3rsc9_ff;
         b10_ff    <= b9_ff + k6rsc9_ff;
         // stage 11
         amag11_ff <= amag11_in;
         den11_ff  <= den11_in;
         // stage 12: distortion factor
         d12_ff <= d12_in;
         // stage 13: radial and tangential products
         m1x13_ff <= side_ff[12].xp * d12_ff;
         m2x13_ff <= $signed({1'b0, side_ff[12].tx2}) * p2;
         m3x13_ff <= side_ff[12].xy24 * p1;
         m1y13_ff <= side_ff[12].yp * d12_ff;
         m2y13_ff <= $signed({1'b0, side_ff[12].ty2}) * p1;
         m3y13_ff <= side_ff[12].xy24 * p2;
         // stage 14
         sx14_ff <= m1x13_ff + m2x13_ff + (m3x13_ff <<< 1);
         sy14_ff <= m1y13_ff + m2y13_ff + (m3y13_ff <<< 1);
         // stage 15: back to normalized plane
         xd15_ff <= clamp32(trunc_q24(sx14_ff) + 64'(codx));
         yd15_ff <= clamp32(trunc_q24(sy14_ff) + 64'(cody));
         // stage 16: focal scale
         mu16_ff <= xd15_ff * fx;
         mv16_ff <= yd15_ff * fy;
         // stage 17: principal point, saturate
         u17_ff <= u17_in;
         v17_ff <= v17_in;
      end
   end

   // ---------------------------------------------------------------- output queue
   assign push       = ce && vld_ff[17];
   assign pop        = rsp_chan.valid && rsp_chan.ready;
   assign push_entry = '{u: u17_ff, v: v17_ff, status: side_ff[17].status};

   always_ff @(posedge clock) begin
      if (reset) begin
         q_count_ff <= '0;
      end else begin
         case ({push, pop})
            2'b10:   q_count_ff <= q_count_ff + 2'd1;
            2'b01:   q_count_ff <= q_count_ff - 2'd1;
            default: q_count_ff <= q_count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case ({push, pop})
         2'b11: begin
            if (q_count_ff == 2'd1) begin
               q_ff[0] <= push_entry;
            end else begin
               q_ff[0] <= q_ff[1];
               q_ff[1] <= push_entry;
            end
         end
         2'b10: begin
            if (q_count_ff == 2'd0) q_ff[0] <= push_entry;
            else                    q_ff[1] <= push_entry;
         end
         2'b01:   q_ff[0] <= q_ff[1];
         default: ;
      endcase
   end

   assign rsp_chan.valid   = (q_count_ff != 2'd0);
   assign rsp_chan.pixel_u = q_ff[0].u;
   assign rsp_chan.pixel_v = q_ff[0].v;
   assign rsp_chan.status  = q_ff[0].status;

endmodule
`default_nettype wire

[sv/rlp_checker.sv]
`default_nettype none
module rlp_checker import rlp_pkg::*; (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic signed [31:0]   rsp_u,
   input wire logic signed [31:0]   rsp_v,
   input wire logic [1:0]           rsp_status,
   input wire logic                 csr_we,
   input wire logic [CSR_IDX_W-1:0] csr_index,
   input wire logic [63:0]          csr_wdata
);

   // shadow of the focal register as seen on the csr port
   logic [63:0] focal_ff;
   logic        focal_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_ff <= '0;
      end else if (csr_we && csr_index == REG_FOCAL) begin
         focal_ff <= csr_wdata;
      end
   end

   assign focal_ok = ($signed(focal_ff[63:32]) > 32'sd0) && ($signed(focal_ff[31:0]) > 32'sd0);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp transaction dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_u) && $stable(rsp_v) && $stable(rsp_status))
      else $error("rsp payload changed while stalled");

   a_zero_pixel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_u == 32'sd0 && rsp_v == 32'sd0)
      else $error("nonzero pixel with failing status");

   a_cfg_bad: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_CONFIG |-> !focal_ok)
      else $error("config error reported with valid focal lengths");

   a_cfg_good: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_OK || rsp_status == ST_FIELD) |-> focal_ok)
      else $error("projection done with bad focal lengths");

endmodule

bind rational_lens_projection_core rlp_checker u_rlp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_u      (rsp_chan.pixel_u),
   .rsp_v      (rsp_chan.pixel_v),
   .rsp_status (rsp_chan.status),
   .csr_we     (csr_we),
   .csr_index  (csr_index),
   .csr_wdata  (csr_wdata)
);
`default_nettype wire

[tb/tb_rational_lens_projection_core.sv]
`timescale 1ns / 100ps
`default_nettype none
// testbench for the rational-lens projection core
// points go in over the request channel, pixels come back over the response
// channel; every accepted point is projected by a fixed-point model kept here
// and the expected pixel is queued, then matched against each response in order
module tb_rational_lens_projection_core;
   import rlp_pkg::*;

   localparam longint ONE_Q24     = 64'sd16777216;
   localparam longint unsigned FIELD_LIMIT = 64'd28521267;
   localparam int     PRESSURE_HOLD = 400;
   localparam int     IDLE_LIMIT    = 3000;
   localparam int     DRAIN_CYCLES  = 180;

   typedef struct {
      logic signed [31:0] pixel_u;
      logic signed [31:0] pixel_v;
      status_type         status;
   } pixel_type;

   logic              clock;
   logic              reset;
   logic              csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [63:0]       csr_wdata;

   rlp_req_if req ();
   rlp_rsp_if rsp ();

   rational_lens_projection_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req),
      .rsp_chan  (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow copy of the register file, updated when a write happens
   logic [63:0] lens_regs [0:6];
   pixel_type   pending_pixels [$];
   int          mismatch_count;
   int          pressure_request;
   int          response_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // fixed-point projection, bit for bit with the block
   // ------------------------------------------------------------------
   function automatic longint sat32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint upper_half(input logic [63:0] r);
      return longint'($signed(r[63:32]));
   endfunction

   function automatic longint lower_half(input logic [63:0] r);
      return longint'($signed(r[31:0]));
   endfunction

   function automatic pixel_type project_point(input logic signed [31:0] pt_x,
                                               input logic signed [31:0] pt_y,
                                               input logic signed [31:0] pt_z);
      pixel_type px;
      longint x, y, z, fx, fy, cx, cy, k1, k2, k3, k4, k5, k6, p1, p2, codx, cody;
      longint xp, yp, rs48, rs24, rss24, rsc24, a48, b48, b24, d24;
      longint xy24, sx, sy, xd, yd;
      longint unsigned ax, ay, r2;
      x = longint'(pt_x);
      y = longint'(pt_y);
      z = longint'(pt_z);
      fx = upper_half(lens_regs[REG_FOCAL]);      fy = lower_half(lens_regs[REG_FOCAL]);
      cx = upper_half(lens_regs[REG_PRINCIPAL]);  cy = lower_half(lens_regs[REG_PRINCIPAL]);
      k1 = upper_half(lens_regs[REG_RAD_NUM]);    k2 = lower_half(lens_regs[REG_RAD_NUM]);
      k3 = upper_half(lens_regs[REG_RAD_MIXED]);  k4 = lower_half(lens_regs[REG_RAD_MIXED]);
      k5 = upper_half(lens_regs[REG_RAD_DEN]);    k6 = lower_half(lens_regs[REG_RAD_DEN]);
      p1 = upper_half(lens_regs[REG_TANGENT]);    p2 = lower_half(lens_regs[REG_TANGENT]);
      codx = upper_half(lens_regs[REG_CENTRE]);   cody = lower_half(lens_regs[REG_CENTRE]);
      px.pixel_u = '0;
      px.pixel_v = '0;
      if (z <= 0) begin
         px.status = ST_DEPTH;
         return px;
      end
      if (fx <= 0 || fy <= 0) begin
         px.status = ST_CONFIG;
         return px;
      end
      xp = sat32((x * ONE_Q24) / z - codx);
      yp = sat32((y * ONE_Q24) / z - cody);
      ax = (xp < 0) ? longint'(-xp) : xp;
      ay = (yp < 0) ? longint'(-yp) : yp;
      r2 = ax * ax + ay * ay;
      if (r2 > FIELD_LIMIT * FIELD_LIMIT) begin
         px.status = ST_FIELD;
         return px;
      end
      rs48  = longint'(r2);
      rs24  = longint'(r2 >> 24);
      rss24 = (rs24 * rs24) >>> 24;
      rsc24 = (rss24 * rs24) >>> 24;
      a48 = ONE_Q24 * ONE_Q24 + k1 * rs24 + k2 * rss24 + k3 * rsc24;
      b48 = ONE_Q24 * ONE_Q24 + k4 * rs24 + k5 * rss24 + k6 * rsc24;
      b24 = b48 / ONE_Q24;
      // zero denominator: ratio falls back to the numerator alone
      d24 = (b24 == 0) ? a48 / ONE_Q24 : a48 / b24;
      d24 = sat32(d24);
      xy24 = (xp * yp) / ONE_Q24;
      sx = xp * d24 + ((rs48 + 2 * xp * xp) / ONE_Q24) * p2 + 2 * xy24 * p1;
      sy = yp * d24 + ((rs48 + 2 * yp * yp) / ONE_Q24) * p1 + 2 * xy24 * p2;
      xd = sat32(sx / ONE_Q24 + codx);
      yd = sat32(sy / ONE_Q24 + cody);
      px.pixel_u = 32'(sat32((xd * fx) / ONE_Q24 + cx));
      px.pixel_v = 32'(sat32((yd * fy) / ONE_Q24 + cy));
      px.status  = ST_OK;
      return px;
   endfunction

   // ------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------
   task automatic send_point(input logic signed [31:0] pt_x,
                             input logic signed [31:0] pt_y,
                             input logic signed [31:0] pt_z);
      int gap_pick;
      int gap;
      gap_pick = $urandom_range(0, 99);
      if (gap_pick < 60) gap = 0;
      else if (gap_pick < 95) gap = $urandom_range(1, 3);
      else gap = $urandom_range(10, 40);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      // valid stays high across back-to-back transactions
      req.valid   <= 1'b1;
      req.point_x <= pt_x;
      req.point_y <= pt_y;
      req.point_z <= pt_z;
      do @(posedge clock); while (!req.ready);
      pending_pixels.push_back(project_point(pt_x, pt_y, pt_z));
   endtask

   // let everything in flight come out before touching the registers
   task automatic drain_pipeline;
      req.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_lens(input logic [63:0] focal, input logic [63:0] principal,
                            input logic [63:0] rad_num, input logic [63:0] rad_mixed,
                            input logic [63:0] rad_den, input logic [63:0] tangent,
                            input logic [63:0] centre);
      logic [63:0] values [0:6];
      values = '{focal, principal, rad_num, rad_mixed, rad_den, tangent, centre};
      drain_pipeline();
      for (int i = 0; i < 7; i++) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= values[i];
         @(posedge clock);
         lens_regs[i] = values[i];
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] small_coeff(input int span);
      return 32'($signed($urandom_range(0, 2 * span)) - span);
   endfunction

   function automatic logic [63:0] coeff_pair(input int span);
      return {small_coeff(span), small_coeff(span)};
   endfunction

   // a typical lens with random but moderate distortion
   task automatic load_random_lens;
      load_lens({32'($urandom_range(1 << 21, 1 << 23)), 32'($urandom_range(1 << 21, 1 << 23))},
                coeff_pair(1 << 22), coeff_pair(1 << 23), coeff_pair(1 << 23),
                coeff_pair(1 << 22), coeff_pair(1 << 20), coeff_pair(1 << 21));
   endtask

   // mostly in-field points with positive depth, some noise and bad depths
   task automatic send_random_point;
      int pick;
      longint z, xn, yn;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         send_point($urandom, $urandom, $urandom);
      end else if (pick == 1) begin
         send_point($urandom, $urandom, -$signed($urandom_range(0, 32'h7fffffff)));
      end else begin
         z  = (pick == 2) ? longint'($urandom_range(1, 32'h7fffffff))
                          : longint'($urandom_range(1 << 12, 1 << 24));
         xn = longint'($urandom_range(0, 44000000)) - 22000000;
         yn = longint'($urandom_range(0, 44000000)) - 22000000;
         send_point(32'((xn * z) >>> 24), 32'((yn * z) >>> 24), 32'(z));
      end
   endtask

   // ------------------------------------------------------------------
   // test tasks
   // ------------------------------------------------------------------
   task automatic test_reset_registers;
      // focal length is zero after reset
      send_point(32'sh00010000, 32'sh00010000, 32'sh00010000);
      send_point(32'sh00010000, 32'sh00010000, 32'sh00000000);
   endtask

   task automatic test_depth_and_focal;
      load_lens({32'sh00400000, 32'sh00400000}, {32'sh00140000, 32'sh000f0000},
                '0, '0, '0, '0, '0);
      send_point(32'sh00010000, 32'sh00010000, 32'sh00000000);
      send_point(32'sh7fffffff, 32'sh80000000, 32'sh80000000);
      send_point(32'sh00000000, 32'sh00000000, 32'shffffffff);
      send_point(32'sh00000000, 32'sh00000000, 32'sh00000001);
      send_point(32'sh00008000, 32'shffff8000, 32'sh00010000);
      send_point(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
      // just inside and just outside the field edge
      send_point(32'sh0001b333, 32'sh00000000, 32'sh00010000);
      send_point(32'sh0001b400, 32'sh00000000, 32'sh00010000);
      send_point(32'sh80000000, 32'sh7fffffff, 32'sh00000001);
      // negative focal lengths
      load_lens({32'shffffffff, 32'sh00400000}, '0, '0, '0, '0, '0, '0);
      send_point(32'sh00010000, 32'sh00010000, 32'sh00010000);
      send_point(32'sh00010000, 32'sh00010000, 32'sh00000000);
      load_lens({32'sh00400000, 32'sh80000000}, '0, '0, '0, '0, '0, '0);
      send_point(32'sh00010000, 32'sh00010000, 32'sh00010000);
   endtask

   task automatic test_zero_denominator;
      // k4 = -1 makes the denominator vanish at unit radius
      load_lens({32'sh00400000, 32'sh00400000}, '0, {32'sh00800000, 32'sh00000000},
                {32'sh00000000, 32'shff000000}, '0, '0, '0);
      send_point(32'sh00010000, 32'sh00000000, 32'sh00010000);
      send_point(32'sh00000000, 32'shffff0000, 32'sh00010000);
      send_point(32'sh00008000, 32'sh00000000, 32'sh00010000);
   endtask

   task automatic test_saturation;
      load_lens({32'sh7fffffff, 32'sh7fffffff}, {32'sh7fffffff, 32'sh80000000},
                {32'sh7fffffff, 32'sh7fffffff}, {32'sh7fffffff, 32'sh00000000},
                '0, {32'sh7fffffff, 32'sh80000000}, {32'sh01000000, 32'shff000000});
      send_point(32'sh00010000, 32'sh00010000, 32'sh00010000);
      send_point(32'shffff8000, 32'sh00008000, 32'sh00010000);
      send_point(32'sh00000000, 32'sh00000000, 32'sh7fffffff);
      load_lens({32'sh00000001, 32'sh00000001}, {32'sh80000000, 32'sh7fffffff},
                {32'sh80000000, 32'sh80000000}, {32'sh80000000, 32'sh80000000},
                {32'sh80000000, 32'sh80000000}, {32'sh80000000, 32'sh7fffffff},
                {32'sh80000000, 32'sh7fffffff});
      send_point(32'sh00010000, 32'sh00010000, 32'sh00010000);
      send_random_point();
      load_lens('1, '1, '1, '1, '1, '1, '1);
      send_point(32'sh00010000, 32'sh00010000, 32'sh00010000);
      load_lens({32'sh7fffffff, 32'sh7fffffff}, {32'sh7fffffff, 32'sh7fffffff},
                {32'sh7fffffff, 32'sh7fffffff}, {32'sh7fffffff, 32'sh7fffffff},
                {32'sh7fffffff, 32'sh7fffffff}, {32'sh7fffffff, 32'sh7fffffff},
                {32'sh00000000, 32'sh00000000});
      send_point(32'sh00010000, 32'shffff0000, 32'sh00010000);
   endtask

   task automatic test_random_lenses;
      for (int phase = 0; phase < 6; phase++) begin
         load_random_lens();
         // one phase runs against a long response stall so the core backs up
         if (phase == 2) pressure_request++;
         repeat (320) send_random_point();
      end
   endtask

   // ------------------------------------------------------------------
   // response side
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      $display("mismatch on response %0d: %s got %h expected %h",
               response_count, what, got, want);
   endtask

   // ready driver: random stalls, plus a long hold when asked
   initial begin
      int pressure_seen;
      int hold_left;
      int pick;
      pressure_seen = 0;
      hold_left = 0;
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (pressure_seen != pressure_request) begin
            pressure_seen = pressure_request;
            hold_left = PRESSURE_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp.ready <= 1'b0;
         end else begin
            pick = $urandom_range(0, 199);
            if (pick < 6) begin
               hold_left = $urandom_range(10, 50);
               rsp.ready <= 1'b0;
            end else begin
               rsp.ready <= (pick < 150) || (pick >= 190);
            end
         end
      end
   end

   // compares each response transaction with the oldest expected pixel
   initial begin
      pixel_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp.valid && rsp.ready) begin
            if (pending_pixels.size() == 0) begin
               // response with nothing expected
               report_mismatch("unexpected pixel_u", rsp.pixel_u, 32'd0);
            end else begin
               want = pending_pixels.pop_front();
               if (rsp.pixel_u !== want.pixel_u)
                  report_mismatch("pixel_u", rsp.pixel_u, want.pixel_u);
               if (rsp.pixel_v !== want.pixel_v)
                  report_mismatch("pixel_v", rsp.pixel_v, want.pixel_v);
               if (rsp.status !== want.status)
                  report_mismatch("status", 32'(rsp.status), 32'(want.status));
            end
            response_count++;
         end
      end
   end

   // watchdog: cycles without any transaction on either channel
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      mismatch_count   = 0;
      pressure_request = 0;
      response_count   = 0;
      for (int i = 0; i < 7; i++) lens_regs[i] = '0;
      reset       <= 1'b1;
      req.valid   <= 1'b0;
      req.point_x <= '0;
      req.point_y <= '0;
      req.point_z <= '0;
      csr_we      <= 1'b0;
      csr_index   <= '0;
      csr_wdata   <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_registers();
      test_depth_and_focal();
      test_zero_denominator();
      test_saturation();
      test_random_lenses();

      drain_pipeline();
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
`default_nettype wire

[sim.f]
sv/rlp_pkg.sv
sv/rlp_ifs.sv
sv/rlp_divider.sv
sv/rational_lens_projection_core.sv
sv/rlp_checker.sv
tb/tb_rational_lens_projection_core.sv
